// ===== design/spf_pkg.sv =====
// Shared types and constants for the sensor packet framer.
// Used by every module of the block; depends on nothing.
package spf_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned POS_W = 6;

  // Byte positions within the framed stream of one packet.
  localparam logic [POS_W-1:0] POS_FIRST_SUMMED = 6'd3;
  localparam logic [POS_W-1:0] POS_PAYLOAD      = 6'd38;
  localparam logic [POS_W-1:0] POS_END_MARK     = 6'd39;
  localparam logic [POS_W-1:0] POS_CSUM         = 6'd40;

  localparam logic [7:0] START_DELIM = 8'h7E;
  localparam logic [7:0] FRAME_TYPE  = 8'h10;
  localparam logic [7:0] END_MARK    = 8'hEE;
  localparam logic [8:0] OUTER_EXTRA = 9'd36;
  localparam logic [7:0] INNER_EXTRA = 8'd9;

  typedef enum logic [2:0] {
    CFG_DEST_ADDR64    = 3'd0,
    CFG_DEST_ADDR16    = 3'd1,
    CFG_FRAME_ID       = 3'd2,
    CFG_RADIUS_OPTIONS = 3'd3,
    CFG_INNER_TYPE     = 3'd4,
    CFG_INNER_ADDRESS  = 3'd5,
    CFG_NODE_CLUSTER   = 3'd6,
    CFG_UNUSED         = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [63:0] dest_addr64;
    logic [15:0] dest_addr16;
    logic [7:0]  frame_id;
    logic [15:0] radius_and_options;
    logic [15:0] inner_type_word;
    logic [55:0] inner_address;
    logic [23:0] node_cluster_command;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    dest_addr64:          64'd5526146524104506,
    dest_addr16:          16'd65534,
    frame_id:             8'd0,
    radius_and_options:   16'd0,
    inner_type_word:      16'd512,
    inner_address:        56'd5526146522291205,
    node_cluster_command: 24'd65794
  };

  // One classified payload byte, as handed from the front end to the back end.
  typedef struct packed {
    logic        first;
    logic        last;
    logic [7:0]  data_byte;
    logic [7:0]  length;
    logic [15:0] total_samples;
    logic [7:0]  sequence_req;
    logic [7:0]  channel;
    logic        compressed;
  } cmd_t;

endpackage

// ===== design/spf_front.sv =====
// Front end of the packet framer: accepts payload bytes and marks packet edges.
// Depends on spf_pkg.
module spf_front import spf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // data_byte, pkt_len, total_samples, sequence_req, channel
  input  logic        s_tuser,  // compressed
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;
  logic [7:0] eff_length;
  logic       in_fire;

  assign s_tready = !q_full;
  assign in_fire  = s_tvalid && s_tready;
  assign q_push   = in_fire;

  // A zero length is framed as a one-byte packet.
  assign eff_length = (s_tdata[15:8] == 8'd0) ? 8'd1 : s_tdata[15:8];

  always_comb begin
    q_cmd.data_byte     = s_tdata[7:0];
    q_cmd.length        = eff_length;
    q_cmd.total_samples = s_tdata[31:16];
    q_cmd.sequence_req  = s_tdata[39:32];
    q_cmd.channel       = s_tdata[47:40];
    q_cmd.compressed    = s_tuser;
    q_cmd.first         = (bytes_left == 8'd0);
    if (bytes_left == 8'd0) begin
      q_cmd.last      = (eff_length == 8'd1);
      bytes_left_next = eff_length - 8'd1;
    end else begin
      q_cmd.last      = (bytes_left == 8'd1);
      bytes_left_next = bytes_left - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= 8'd0;
    end else if (in_fire) begin
      bytes_left <= bytes_left_next;
    end
  end

endmodule

// ===== design/spf_queue.sv =====
// Short command queue between the front and back ends of the framer.
// Depends on spf_pkg.
module spf_queue import spf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond its depth");

endmodule

// ===== design/spf_back.sv =====
// Back end of the framer: expands queued commands into header, payload,
// end mark and checksum bytes. Depends on spf_pkg.
module spf_back import spf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_regs_t  cfg,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // out_byte
  output logic       m_tlast   // frame_end
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] eff_pos;
  logic [7:0]       running_sum;
  logic [7:0]       byte_val;
  logic [8:0]       len_outer;
  logic [7:0]       inner_len;
  logic [8:0]       len_inner;
  logic             emit;
  logic             entry_done;

  assign eff_pos   = head_cmd.first ? pos : pos + POS_PAYLOAD;
  assign len_outer = {1'b0, head_cmd.length} + OUTER_EXTRA;
  assign inner_len = head_cmd.length + INNER_EXTRA;
  assign len_inner = {1'b0, inner_len} + {1'b0, INNER_EXTRA};

  assign emit       = head_valid && (!m_tvalid || m_tready);
  assign entry_done = (eff_pos == POS_CSUM) || (eff_pos == POS_PAYLOAD && !head_cmd.last);
  assign pop        = emit && entry_done;

  always_comb begin
    unique case (eff_pos)
      6'd0:  byte_val = START_DELIM;
      6'd1:  byte_val = {7'd0, len_outer[8]};
      6'd2:  byte_val = len_outer[7:0];
      6'd3:  byte_val = FRAME_TYPE;
      6'd4:  byte_val = cfg.frame_id;
      6'd5:  byte_val = cfg.dest_addr64[63:56];
      6'd6:  byte_val = cfg.dest_addr64[55:48];
      6'd7:  byte_val = cfg.dest_addr64[47:40];
      6'd8:  byte_val = cfg.dest_addr64[39:32];
      6'd9:  byte_val = cfg.dest_addr64[31:24];
      6'd10: byte_val = cfg.dest_addr64[23:16];
      6'd11: byte_val = cfg.dest_addr64[15:8];
      6'd12: byte_val = cfg.dest_addr64[7:0];
      6'd13: byte_val = cfg.dest_addr16[15:8];
      6'd14: byte_val = cfg.dest_addr16[7:0];
      6'd15: byte_val = cfg.radius_and_options[15:8];
      6'd16: byte_val = cfg.radius_and_options[7:0];
      6'd17: byte_val = START_DELIM;
      6'd18: byte_val = {7'd0, len_inner[8]};
      6'd19: byte_val = len_inner[7:0];
      6'd20: byte_val = cfg.inner_type_word[15:8];
      6'd21: byte_val = cfg.inner_type_word[7:0];
      6'd22: byte_val = cfg.inner_address[55:48];
      6'd23: byte_val = cfg.inner_address[47:40];
      6'd24: byte_val = cfg.inner_address[39:32];
      6'd25: byte_val = cfg.inner_address[31:24];
      6'd26: byte_val = cfg.inner_address[23:16];
      6'd27: byte_val = cfg.inner_address[15:8];
      6'd28: byte_val = cfg.inner_address[7:0];
      6'd29: byte_val = inner_len;
      6'd30: byte_val = cfg.node_cluster_command[23:16];
      6'd31: byte_val = cfg.node_cluster_command[15:8];
      6'd32: byte_val = cfg.node_cluster_command[7:0];
      6'd33: byte_val = {7'd0, head_cmd.compressed};
      6'd34: byte_val = head_cmd.total_samples[15:8];
      6'd35: byte_val = head_cmd.total_samples[7:0];
      6'd36: byte_val = head_cmd.sequence_req;
      6'd37: byte_val = head_cmd.channel;
      6'd38: byte_val = head_cmd.data_byte;
      6'd39: byte_val = END_MARK;
      6'd40: byte_val = ~running_sum;
      default: byte_val = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      running_sum <= 8'd0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !emit) begin
        m_tvalid <= 1'b0;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
        pos      <= entry_done ? '0 : pos + 1'b1;
        // The checksum covers everything after the outer length field.
        if (eff_pos == '0) begin
          running_sum <= 8'd0;
        end else if (eff_pos >= POS_FIRST_SUMMED && eff_pos <= POS_END_MARK) begin
          running_sum <= running_sum + byte_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= byte_val;
      m_tlast <= (eff_pos == POS_CSUM);
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
      head_valid |-> (eff_pos <= POS_CSUM))
    else $error("byte position beyond the end of a frame");
  a_csum_pops: assert property (@(posedge clk) disable iff (rst)
      (emit && eff_pos == POS_CSUM) |-> (pop && head_cmd.last))
    else $error("checksum emitted for an entry that does not close its packet");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output transaction changed while stalled");

endmodule

// ===== design/sensor_packet_framer.sv =====
// Sensor packet framer: builds a two-level radio frame around payload bytes.
// Input channel s_*: one payload byte per transaction; the first byte of a
// packet also carries its length, total sample count, sequence and channel.
// Output channel m_*: the framed byte stream, tlast on each checksum byte.
// Configuration channel cfg_*: register writes, always ready; values are
// used by header bytes emitted after the write.
// Each accepted byte is queued; its output bytes leave via the output register.
// Throughput: one output byte per cycle while m_tready is high and a command
// is queued, set by the single byte-wide output register; a packet of n bytes
// becomes n + 40 output bytes. Input bytes are taken one per cycle while the
// four-entry command queue has room, so the input stalls during the 38-byte
// header burst once the queue fills.
// Reset clears the byte counter, byte position, queue and output valid;
// configuration registers return to their default values.
// When the receiver stalls, the output byte is held and the queue fills,
// then s_tready drops until bytes drain.
// Depends on spf_pkg, spf_front, spf_queue and spf_back.
module sensor_packet_framer import spf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // data_byte, pkt_len, total_samples, sequence_req, channel
  input  logic        s_tuser,  // compressed
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // out_byte
  output logic        m_tlast,  // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_regs_t cfg;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      head_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DEST_ADDR64:    cfg.dest_addr64          <= cfg_data;
        CFG_DEST_ADDR16:    cfg.dest_addr16          <= cfg_data[15:0];
        CFG_FRAME_ID:       cfg.frame_id             <= cfg_data[7:0];
        CFG_RADIUS_OPTIONS: cfg.radius_and_options   <= cfg_data[15:0];
        CFG_INNER_TYPE:     cfg.inner_type_word      <= cfg_data[15:0];
        CFG_INNER_ADDRESS:  cfg.inner_address        <= cfg_data[55:0];
        CFG_NODE_CLUSTER:   cfg.node_cluster_command <= cfg_data[23:0];
        CFG_UNUSED:         ;
        default:            ;
      endcase
    end
  end

  spf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  spf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  spf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
